### design/ataa_pkg.sv
// Shared types, register map and a clamp helper for the three-axis augmentor.
// Used by ataa_ctrl, ataa_dp, adaptive_three_axis_augmentor and the bench; no dependencies.
`timescale 1ns / 1ps

package ataa_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LEARN_RATE = 3'd0;
    localparam logic [2:0] REG_LEAKAGE    = 3'd1;
    localparam logic [2:0] REG_WEIGHT_LIM = 3'd2;
    localparam logic [2:0] REG_ROLL_LIM   = 3'd3;
    localparam logic [2:0] REG_PITCH_LIM  = 3'd4;
    localparam logic [2:0] REG_YAW_LIM    = 3'd5;
    localparam logic [2:0] REG_FREEZE     = 3'd6;

    // Datapath widths
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 56;
    localparam int G_W     = 30;
    localparam int L_W     = 42;

    // Regressor constant 1.0 in Q4.12
    localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

    // Micro-operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_C0,
        OP_CE,
        OP_CR,
        OP_CEND,
        OP_GMUL,
        OP_GSAVE,
        OP_LMUL,
        OP_AMUL,
        OP_DIFF,
        OP_DMUL,
        OP_WUPD,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic [1:0] widx;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
    } t_dp_status;

    typedef struct packed {
        logic [23:0]      learn_rate;
        logic [23:0]      leakage;
        logic [30:0]      weight_lim;
        logic [2:0][30:0] axis_lim;
        logic             freeze;
    } t_cfg;

    // Symmetric clamp to +-lim
    function automatic logic signed [31:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                     input logic [30:0] lim);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] res;
        hi = $signed({{(ACC_W-31){1'b0}}, lim});
        lo = -hi;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res[31:0];
    endfunction

endpackage

### design/ataa_ctrl.sv
// Sequencer for the augmentor: handshakes, step counters and micro-op issue.
// Depends on ataa_pkg; drives ataa_dp through t_dp_cmd.
`timescale 1ns / 1ps

module ataa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  ataa_pkg::t_dp_status i_status,
    output ataa_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_C0, S_CE, S_CR, S_CEND,
        S_GMUL, S_GSAVE, S_LMUL, S_AMUL, S_DIFF, S_DMUL, S_WUPD,
        S_FIN
    } t_state;

    t_state     r_state;
    logic [1:0] r_axis;
    logic [1:0] r_widx;
    logic       r_m_valid;
    logic       slot_free;
    logic       accept;
    ataa_pkg::t_op op;

    assign slot_free  = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;

    // Decode the micro-op for this cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  op = accept ? ataa_pkg::OP_LOAD : ataa_pkg::OP_NONE;
            S_C0:    op = ataa_pkg::OP_C0;
            S_CE:    op = ataa_pkg::OP_CE;
            S_CR:    op = ataa_pkg::OP_CR;
            S_CEND:  op = ataa_pkg::OP_CEND;
            S_GMUL:  op = ataa_pkg::OP_GMUL;
            S_GSAVE: op = ataa_pkg::OP_GSAVE;
            S_LMUL:  op = ataa_pkg::OP_LMUL;
            S_AMUL:  op = ataa_pkg::OP_AMUL;
            S_DIFF:  op = ataa_pkg::OP_DIFF;
            S_DMUL:  op = ataa_pkg::OP_DMUL;
            S_WUPD:  op = ataa_pkg::OP_WUPD;
            S_FIN:   op = slot_free ? ataa_pkg::OP_FIN : ataa_pkg::OP_NONE;
            default: op = ataa_pkg::OP_NONE;
        endcase
    end

    assign o_cmd.op   = op;
    assign o_cmd.axis = r_axis;
    assign o_cmd.widx = r_widx;

    // State, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= 2'd0;
            r_widx    <= 2'd0;
            r_m_valid <= 1'b0;
        end else begin
            // Raise valid on finish, drop it once the beat is taken
            if (op == ataa_pkg::OP_FIN) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_C0;
                        r_axis  <= 2'd0;
                        r_widx  <= 2'd0;
                    end
                end
                S_C0: r_state <= S_CE;
                S_CE: r_state <= S_CR;
                S_CR: r_state <= S_CEND;
                S_CEND: begin
                    if (r_axis == 2'd2) begin
                        r_axis  <= 2'd0;
                        r_state <= i_status.active ? S_GMUL : S_FIN;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_C0;
                    end
                end
                S_GMUL:  r_state <= S_GSAVE;
                S_GSAVE: r_state <= S_LMUL;
                S_LMUL:  r_state <= S_AMUL;
                S_AMUL:  r_state <= S_DIFF;
                S_DIFF:  r_state <= S_DMUL;
                S_DMUL:  r_state <= S_WUPD;
                S_WUPD: begin
                    if (r_widx == 2'd2) begin
                        r_widx <= 2'd0;
                        if (r_axis == 2'd2) begin
                            r_axis  <= 2'd0;
                            r_state <= S_FIN;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_GMUL;
                        end
                    end else begin
                        r_widx  <= r_widx + 2'd1;
                        r_state <= S_LMUL;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_fin_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == ataa_pkg::OP_FIN) |-> slot_free)
        else $error("result published over an untaken beat");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_C0 && r_axis == 2'd0))
        else $error("accepted beat did not start the command pass");
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_axis != 2'd3) && (r_widx != 2'd3))
        else $error("axis or weight counter out of range");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == ataa_pkg::OP_FIN) |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("finish did not raise output valid");
`endif

endmodule

### design/ataa_dp.sv
// Datapath: weight registers, shared multiplier, accumulator and result registers.
// Depends on ataa_pkg; sequenced by ataa_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module ataa_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ataa_pkg::t_cfg       i_cfg,
    input  ataa_pkg::t_dp_cmd    i_cmd,
    output ataa_pkg::t_dp_status o_status,
    input  logic [111:0]         i_tdata,
    input  logic [1:0]           i_tuser,
    output logic [95:0]          o_tdata,
    output logic                 o_tuser
);

    logic signed [15:0] r_e [3];
    logic signed [15:0] r_r [3];
    logic [15:0]        r_dt;
    logic               r_active;
    logic               r_clear;
    logic signed [31:0] r_w [9];
    logic signed [ataa_pkg::PROD_W-1:0]  r_p;
    logic signed [ataa_pkg::ACC_W-1:0]   r_acc;
    logic signed [ataa_pkg::G_W-1:0]     r_g;
    logic signed [ataa_pkg::L_W-1:0]     r_l;
    logic signed [ataa_pkg::L_W-1:0]     r_diff;
    logic signed [31:0] r_cmd [3];
    logic signed [31:0] r_out [3];
    logic               r_out_act;

    logic [3:0]  widx_sel;
    logic [3:0]  w_addr;
    logic signed [31:0] w_rd;
    logic signed [15:0] e_sel;
    logic signed [15:0] r_sel;
    logic signed [15:0] phi;
    logic signed [ataa_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ataa_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ataa_pkg::PROD_W-1:0]  n_p;
    logic signed [ataa_pkg::ACC_W-1:0]   sum_w;
    logic signed [ataa_pkg::ACC_W-1:0]   sum_c;

    assign o_status.active = r_active;

    // Weight address: fixed offsets for the command pass, counter for learning
    always_comb begin
        unique case (i_cmd.op)
            ataa_pkg::OP_C0: widx_sel = 4'd0;
            ataa_pkg::OP_CE: widx_sel = 4'd1;
            ataa_pkg::OP_CR: widx_sel = 4'd2;
            default:         widx_sel = {2'd0, i_cmd.widx};
        endcase
    end
    assign w_addr = 4'(i_cmd.axis) * 4'd3 + widx_sel;
    assign w_rd   = r_w[w_addr];
    assign e_sel  = r_e[i_cmd.axis];
    assign r_sel  = r_r[i_cmd.axis];

    always_comb begin
        unique case (i_cmd.widx)
            2'd0:    phi = ataa_pkg::ONE_Q12;
            2'd1:    phi = e_sel;
            default: phi = r_sel;
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            ataa_pkg::OP_CE: begin
                mul_a = ataa_pkg::MUL_A_W'(w_rd);
                mul_b = ataa_pkg::MUL_B_W'(e_sel);
            end
            ataa_pkg::OP_CR: begin
                mul_a = ataa_pkg::MUL_A_W'(w_rd);
                mul_b = ataa_pkg::MUL_B_W'(r_sel);
            end
            ataa_pkg::OP_GMUL: begin
                mul_a = $signed({18'd0, i_cfg.learn_rate});
                mul_b = ataa_pkg::MUL_B_W'(e_sel);
            end
            ataa_pkg::OP_LMUL: begin
                mul_a = ataa_pkg::MUL_A_W'(w_rd);
                mul_b = $signed({1'b0, i_cfg.leakage});
            end
            ataa_pkg::OP_AMUL: begin
                mul_a = ataa_pkg::MUL_A_W'(r_g);
                mul_b = ataa_pkg::MUL_B_W'(phi);
            end
            ataa_pkg::OP_DMUL: begin
                mul_a = r_diff;
                mul_b = $signed({9'd0, r_dt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_p   = ataa_pkg::PROD_W'(mul_a) * ataa_pkg::PROD_W'(mul_b);
    assign sum_c = r_acc + ataa_pkg::ACC_W'(r_p >>> 12);
    assign sum_w = ataa_pkg::ACC_W'(w_rd) + ataa_pkg::ACC_W'(r_p >>> 16);

    // Weight registers: adapt, clear, reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_w[i] <= '0;
            end
        end else if (i_cmd.op == ataa_pkg::OP_FIN && r_clear) begin
            for (int i = 0; i < 9; i++) begin
                r_w[i] <= '0;
            end
        end else if (i_cmd.op == ataa_pkg::OP_WUPD) begin
            r_w[w_addr] <= ataa_pkg::clamp_sym(sum_w, i_cfg.weight_lim);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        unique case (i_cmd.op)
            ataa_pkg::OP_LOAD: begin
                r_e[0]   <= $signed(i_tdata[15:0]);
                r_r[0]   <= $signed(i_tdata[31:16]);
                r_e[1]   <= $signed(i_tdata[47:32]);
                r_r[1]   <= $signed(i_tdata[63:48]);
                r_e[2]   <= $signed(i_tdata[79:64]);
                r_r[2]   <= $signed(i_tdata[95:80]);
                r_dt     <= i_tdata[111:96];
                r_active <= !i_cfg.freeze && i_tuser[0] && (i_tdata[111:96] != 16'd0);
                r_clear  <= i_tuser[1];
            end
            ataa_pkg::OP_C0:    r_acc <= ataa_pkg::ACC_W'(w_rd);
            ataa_pkg::OP_CR:    r_acc <= sum_c;
            ataa_pkg::OP_CEND:  r_cmd[i_cmd.axis] <=
                                    ataa_pkg::clamp_sym(sum_c, i_cfg.axis_lim[i_cmd.axis]);
            ataa_pkg::OP_GSAVE: r_g <= $signed(r_p[12+ataa_pkg::G_W-1:12]);
            ataa_pkg::OP_AMUL:  r_l <= ataa_pkg::L_W'(r_p >>> 16);
            ataa_pkg::OP_DIFF:  r_diff <= ataa_pkg::L_W'(r_p >>> 12) - r_l;
            ataa_pkg::OP_FIN: begin
                r_out[0]  <= r_cmd[0];
                r_out[1]  <= r_cmd[1];
                r_out[2]  <= r_cmd[2];
                r_out_act <= r_active;
            end
            default: begin
            end
        endcase
    end

    assign o_tdata = {r_out[2], r_out[1], r_out[0]};
    assign o_tuser = r_out_act;

endmodule

### design/adaptive_three_axis_augmentor.sv
// Top level: APB register file, stream ports, controller and datapath.
// Depends on ataa_pkg, ataa_ctrl and ataa_dp.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  s stream | in  | tvalid/tready      | tdata 112b errors/rates/time step, tuser 2b
//  m stream | out | tvalid/tready      | tdata 96b commands, tuser 1b
//  apb      | in  | psel/penable/pready| 5b address, 32b data, 7 registers
//
// A tick runs the command pass alone when no adaptation runs and adds the learning
// pass when it does; one shared 42x25 multiplier serves both, one product per cycle.
// Reset is synchronous active low and zeroes weights, control and config registers.
// The result sits in an output register, so a stalled output holds only the
// finish step; the next beat is accepted while the previous result waits.
`timescale 1ns / 1ps

module adaptive_three_axis_augmentor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // roll_error, roll_rate, pitch_error, pitch_rate, yaw_error, yaw_rate, time_step
    input  logic [111:0] i_s_tdata,
    // learn_enable, clear_weights
    input  logic [1:0]   i_s_tuser,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // aileron_cmd, elevator_cmd, rudder_cmd
    output logic [95:0]  o_m_tdata,
    // learning_active
    output logic         o_m_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ataa_pkg::t_cfg       r_cfg;
    ataa_pkg::t_dp_cmd    cmd;
    ataa_pkg::t_dp_status status;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // Register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                ataa_pkg::REG_LEARN_RATE: r_cfg.learn_rate  <= pwdata[23:0];
                ataa_pkg::REG_LEAKAGE:    r_cfg.leakage     <= pwdata[23:0];
                ataa_pkg::REG_WEIGHT_LIM: r_cfg.weight_lim  <= pwdata[30:0];
                ataa_pkg::REG_ROLL_LIM:   r_cfg.axis_lim[0] <= pwdata[30:0];
                ataa_pkg::REG_PITCH_LIM:  r_cfg.axis_lim[1] <= pwdata[30:0];
                ataa_pkg::REG_YAW_LIM:    r_cfg.axis_lim[2] <= pwdata[30:0];
                ataa_pkg::REG_FREEZE:     r_cfg.freeze      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            ataa_pkg::REG_LEARN_RATE: prdata = {8'd0, r_cfg.learn_rate};
            ataa_pkg::REG_LEAKAGE:    prdata = {8'd0, r_cfg.leakage};
            ataa_pkg::REG_WEIGHT_LIM: prdata = {1'b0, r_cfg.weight_lim};
            ataa_pkg::REG_ROLL_LIM:   prdata = {1'b0, r_cfg.axis_lim[0]};
            ataa_pkg::REG_PITCH_LIM:  prdata = {1'b0, r_cfg.axis_lim[1]};
            ataa_pkg::REG_YAW_LIM:    prdata = {1'b0, r_cfg.axis_lim[2]};
            ataa_pkg::REG_FREEZE:     prdata = {31'd0, r_cfg.freeze};
            default:                  prdata = 32'd0;
        endcase
    end

    ataa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ataa_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .o_status (status),
        .i_tdata  (i_s_tdata),
        .i_tuser  (i_s_tuser),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser)
    );

endmodule

### tb/sv/tb_adaptive_three_axis_augmentor.sv
// Self-checking bench for adaptive_three_axis_augmentor: random and directed ticks,
// bit-exact prediction of commands and weight adaptation. Depends on ataa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_adaptive_three_axis_augmentor;

    typedef struct packed {
        logic [15:0] dt;
        logic [15:0] yr;
        logic [15:0] ye;
        logic [15:0] pr;
        logic [15:0] pe;
        logic [15:0] rr;
        logic [15:0] re;
    } t_tick;

    typedef struct {
        logic [95:0] cmds;
        logic        active;
    } t_cmd_out;

    // Fixed-point flight augmentor state and expected command queue
    class augmentor_board;
        longint      w[9];
        logic [23:0] rate_gain, leak_gain;
        logic [30:0] wlim;
        logic [30:0] alim[3];
        logic        frz;
        t_cmd_out    pending[$];
        int          errors;

        function longint fshift(longint x, int k);
            return x >>> k;
        endfunction

        function longint clamp(longint v, logic [30:0] lim);
            longint l;
            l = longint'(lim);
            if (v > l) return l;
            if (v < -l) return -l;
            return v;
        endfunction

        function void note_tick(t_tick t, logic learn, logic clr);
            longint e[3], r[3], phi[3], dt, s, g, a, l, d;
            t_cmd_out o;
            logic act;
            e[0] = longint'($signed(t.re)); r[0] = longint'($signed(t.rr));
            e[1] = longint'($signed(t.pe)); r[1] = longint'($signed(t.pr));
            e[2] = longint'($signed(t.ye)); r[2] = longint'($signed(t.yr));
            dt = longint'(t.dt);
            act = !frz && learn && (dt != 0);
            for (int ax = 0; ax < 3; ax++) begin
                s = w[3*ax] + fshift(w[3*ax+1] * e[ax], 12) + fshift(w[3*ax+2] * r[ax], 12);
                o.cmds[32*ax +: 32] = 32'(clamp(s, alim[ax]));
            end
            o.active = act;
            pending.push_back(o);
            if (act) begin
                for (int ax = 0; ax < 3; ax++) begin
                    g = fshift(longint'(rate_gain) * e[ax], 12);
                    phi[0] = 4096; phi[1] = e[ax]; phi[2] = r[ax];
                    for (int i = 0; i < 3; i++) begin
                        a = fshift(g * phi[i], 12);
                        l = fshift(longint'(leak_gain) * w[3*ax+i], 16);
                        d = fshift((a - l) * dt, 16);
                        w[3*ax+i] = clamp(w[3*ax+i] + d, wlim);
                    end
                end
            end
            if (clr) foreach (w[i]) w[i] = 0;
        endfunction

        function void check_result(logic [95:0] data, logic act);
            t_cmd_out exp_o;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h/%b", data, act);
                return;
            end
            exp_o = pending.pop_front();
            if (exp_o.cmds !== data || exp_o.active !== act) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h/%b got %h/%b",
                             exp_o.cmds, exp_o.active, data, act);
            end
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic [111:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         i_s_tvalid, o_s_tready;
    logic [95:0]  o_m_tdata;
    logic         o_m_tuser, o_m_tvalid, i_m_tready;
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [31:0]  pwdata, prdata;

    augmentor_board board;
    int  cycles;
    bit  calm;
    int  hold_off;

    adaptive_three_axis_augmentor uut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on total run length
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("tb_adaptive_three_axis_augmentor NOT OK");
                $finish;
            end
        end
    end

    // Check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser);
    end

    // Receiver: random stall bursts, or a long hold-off when requested
    initial begin
        i_m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_m_tready <= 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_m_tready <= 1;
            end else begin
                i_m_tready <= 1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            ataa_pkg::REG_LEARN_RATE: board.rate_gain = val[23:0];
            ataa_pkg::REG_LEAKAGE:    board.leak_gain = val[23:0];
            ataa_pkg::REG_WEIGHT_LIM: board.wlim = val[30:0];
            ataa_pkg::REG_ROLL_LIM:   board.alim[0] = val[30:0];
            ataa_pkg::REG_PITCH_LIM:  board.alim[1] = val[30:0];
            ataa_pkg::REG_YAW_LIM:    board.alim[2] = val[30:0];
            ataa_pkg::REG_FREEZE:     board.frz = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_tick(t_tick t, logic learn, logic clr);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_tdata <= t;
        i_s_tuser <= {clr, learn};
        i_s_tvalid <= 1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_tick(t, learn, clr);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_tick rand_tick();
        t_tick t;
        t.re = pick16(); t.rr = pick16(); t.pe = pick16();
        t.pr = pick16(); t.ye = pick16(); t.yr = pick16();
        case ($urandom_range(0, 5))
            0: t.dt = 0;
            1: t.dt = 16'hffff;
            default: t.dt = 16'($urandom);
        endcase
        return t;
    endfunction

    // Random register setting, with extremes mixed in
    task automatic random_config();
        write_reg(ataa_pkg::REG_LEARN_RATE,
                  $urandom_range(0, 3) == 0 ? 32'hffffffff : $urandom);
        write_reg(ataa_pkg::REG_LEAKAGE,
                  $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h30000));
        write_reg(ataa_pkg::REG_WEIGHT_LIM,
                  $urandom_range(0, 4) == 0 ? 32'h7fffffff : $urandom);
        write_reg(ataa_pkg::REG_ROLL_LIM,
                  $urandom_range(0, 3) == 0 ? 32'hffffffff : $urandom);
        write_reg(ataa_pkg::REG_PITCH_LIM,
                  $urandom_range(0, 5) == 0 ? 32'd0 : $urandom);
        write_reg(ataa_pkg::REG_YAW_LIM, $urandom);
        write_reg(ataa_pkg::REG_FREEZE, 32'($urandom_range(0, 5) == 0));
    endtask

    initial begin
        t_tick t;
        board = new();
        foreach (board.w[i]) board.w[i] = 0;
        board.rate_gain = 0; board.leak_gain = 0; board.wlim = 0; board.frz = 0;
        foreach (board.alim[i]) board.alim[i] = 0;
        board.errors = 0;
        calm = 0; hold_off = 0;
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0; i_s_tuser = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: zero limits first, then full range with extremes
        t = t_tick'{default: 16'h7fff};
        send_tick(t, 1, 0);
        drain();
        write_reg(ataa_pkg::REG_LEARN_RATE, 32'h00ffffff);
        write_reg(ataa_pkg::REG_LEAKAGE, 32'h00ffffff);
        write_reg(ataa_pkg::REG_WEIGHT_LIM, 32'h7fffffff);
        write_reg(ataa_pkg::REG_ROLL_LIM, 32'h7fffffff);
        write_reg(ataa_pkg::REG_PITCH_LIM, 32'h7fffffff);
        write_reg(ataa_pkg::REG_YAW_LIM, 32'hffffffff);
        write_reg(ataa_pkg::REG_FREEZE, 32'd0);
        for (int k = 0; k < 16; k++) begin
            t = (k % 2) ? t_tick'{default: 16'h8000} : t_tick'{default: 16'h7fff};
            t.dt = (k % 4 == 3) ? 16'h0 : 16'hffff;
            send_tick(t, k != 5, k == 9 || k == 13);
        end
        drain();
        write_reg(ataa_pkg::REG_FREEZE, 32'd1);
        send_tick(t_tick'{default: 16'h7fff}, 1, 0);
        send_tick(t_tick'{default: 16'h8000}, 1, 1);
        drain();
        write_reg(ataa_pkg::REG_FREEZE, 32'd0);
        write_reg(ataa_pkg::REG_LEAKAGE, 32'd0);

        // Long receiver hold-off while the sender keeps pushing
        hold_off = 300;
        for (int k = 0; k < 8; k++) send_tick(rand_tick(), 1, 0);
        drain();

        // Random phases with config changes between
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            if (ph == 7) calm = 1;
            for (int k = 0; k < 200; k++)
                send_tick(rand_tick(), $urandom_range(0, 4) != 0, $urandom_range(0, 30) == 0);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_adaptive_three_axis_augmentor OK");
        end else begin
            $display("tb_adaptive_three_axis_augmentor NOT OK");
        end
        $finish;
    end
endmodule

### filelist.f
design/ataa_pkg.sv
design/ataa_ctrl.sv
design/ataa_dp.sv
design/adaptive_three_axis_augmentor.sv
tb/sv/tb_adaptive_three_axis_augmentor.sv
